// ===== rtl/core/irpd_pkg.sv =====
// Package for the IR UART packet decoder.
// Holds the limits, field widths, codes and item types shared by all blocks.
// It depends on nothing else.
package irpd_pkg;

    localparam int EDGE_LIMIT = 512;
    localparam int BIT_LIMIT  = 2048;
    localparam int BYTE_LIMIT = 32;

    localparam int RUN_MAX    = 16;
    localparam int PAD_BITS   = 8;
    localparam int LEAD_LEN   = 10;
    localparam int PAY_LEN    = 6;
    localparam int PACKET_MIN = 16;
    localparam int TOTAL_MAX  = 63;

    localparam int BP_W        = 14;
    localparam int MIN_EDGES_W = 10;
    localparam int DUR_W       = 16;
    localparam int CFG_W       = 14;
    localparam int CFG_IDX_W   = 1;
    localparam int TOTAL_W     = 6;

    localparam int EDGE_W    = $clog2(EDGE_LIMIT + 1);
    localparam int BIT_W     = $clog2(BIT_LIMIT + 1);
    localparam int BYTE_W    = $clog2(BYTE_LIMIT + 1);
    localparam int RUN_W     = $clog2(RUN_MAX + 1);
    localparam int DIV_STEPS = $clog2(RUN_MAX);
    localparam int STEP_W    = $clog2(DIV_STEPS + 1);
    localparam int REM_W     = DUR_W + 1;
    localparam int DIVS_W    = BP_W + DIV_STEPS;
    localparam int CMP_W     = (EDGE_W > MIN_EDGES_W ? EDGE_W : MIN_EDGES_W) + 1;
    localparam int SAT_W     = BYTE_W > TOTAL_W ? BYTE_W : TOTAL_W;
    localparam int LEAD_IDX_W = $clog2(LEAD_LEN);

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [CFG_IDX_W-1:0] REG_BIT_PERIOD = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_EDGES  = 1'b1;

    localparam logic [BP_W-1:0]        BIT_PERIOD_RESET = 14'd800;
    localparam logic [MIN_EDGES_W-1:0] MIN_EDGES_RESET  = 10'd30;

    localparam logic ACT_INTERVAL = 1'b0;
    localparam logic ACT_END      = 1'b1;

    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_NOISE   = 2'd1;
    localparam logic [1:0] STATUS_SHORT   = 2'd2;
    localparam logic [1:0] STATUS_BAD_SUM = 2'd3;

    localparam logic [7:0] LEAD_PATTERN [LEAD_LEN] = '{
        8'h5A, 8'hA5, 8'h80, 8'h7F, 8'h40, 8'hBF, 8'h20, 8'hDF, 8'h10, 8'hCC
    };

    typedef struct packed {
        logic             is_end;
        logic             noise;
        logic             level;
        logic [RUN_W-1:0] run_len;
    } q_entry_t;

    typedef struct packed {
        logic [1:0]         status;
        logic               preamble_ok;
        logic [TOTAL_W-1:0] byte_total;
        logic [7:0]         command_flags;
        logic [7:0]         fan_speed;
        logic [7:0]         setpoint_f;
        logic [7:0]         extra_a;
        logic [7:0]         extra_b;
        logic [7:0]         checksum_got;
        logic [7:0]         checksum_calc;
    } result_t;

endpackage

// ===== rtl/core/irpd_if.sv =====
// Valid/ready channel interfaces of the IR UART packet decoder.
// Depends on irpd_pkg for the field widths.
interface irpd_in_if import irpd_pkg::*; ();
    logic             valid;
    logic             ready;
    logic             action;
    logic             level;
    logic [DUR_W-1:0] duration_us;

    modport source (output valid, output action, output level, output duration_us,
                    input ready);
    modport sink (input valid, input action, input level, input duration_us,
                  output ready);
endinterface

interface irpd_out_if import irpd_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [1:0]         status;
    logic               preamble_ok;
    logic [TOTAL_W-1:0] byte_total;
    logic [7:0]         command_flags;
    logic [7:0]         fan_speed;
    logic [7:0]         setpoint_f;
    logic [7:0]         extra_a;
    logic [7:0]         extra_b;
    logic [7:0]         checksum_got;
    logic [7:0]         checksum_calc;

    modport source (output valid, output status, output preamble_ok, output byte_total,
                    output command_flags, output fan_speed, output setpoint_f,
                    output extra_a, output extra_b, output checksum_got,
                    output checksum_calc, input ready);
    modport sink (input valid, input status, input preamble_ok, input byte_total,
                  input command_flags, input fan_speed, input setpoint_f,
                  input extra_a, input extra_b, input checksum_got,
                  input checksum_calc, output ready);
endinterface

// ===== rtl/core/irpd_front.sv =====
// Front end: accepts interval items, counts edges and rounds each duration
// to a run length with a restoring divider. Depends on irpd_pkg and irpd_if.
module irpd_front import irpd_pkg::*; (
    input  logic                   clk,
    input  logic                   rst_n,
    irpd_in_if.sink                interval,
    input  logic [BP_W-1:0]        bit_period_us,
    input  logic [MIN_EDGES_W-1:0] min_edges,
    output logic                   q_valid,
    input  logic                   q_ready,
    output q_entry_t               q_data
);

    typedef enum logic [2:0] {
        F_IDLE = 3'b001,
        F_DIV  = 3'b010,
        F_PUSH = 3'b100
    } front_state_t;

    front_state_t         state_reg, state_next;
    logic [EDGE_W-1:0]    edge_total_reg, edge_total_next;
    logic [REM_W-1:0]     rem_reg, rem_next;
    logic [DIV_STEPS-1:0] quot_reg, quot_next;
    logic [STEP_W-1:0]    step_reg, step_next;
    q_entry_t             entry_reg, entry_next;

    logic [DIVS_W-1:0]    divisor;
    logic                 div_ge;
    logic [DIV_STEPS-1:0] quot_tmp;

    assign divisor = {{(DIVS_W-BP_W){1'b0}}, bit_period_us} << step_reg;
    assign div_ge  = {{(DIVS_W-REM_W){1'b0}}, rem_reg} >= divisor;

    assign interval.ready = (state_reg == F_IDLE);
    assign q_valid        = (state_reg == F_PUSH);
    assign q_data         = entry_reg;

    always_comb
    begin
        state_next      = state_reg;
        edge_total_next = edge_total_reg;
        rem_next        = rem_reg;
        quot_next       = quot_reg;
        step_next       = step_reg;
        entry_next      = entry_reg;
        quot_tmp        = quot_reg;
        case (state_reg)
            F_IDLE:
            begin
                if (interval.valid)
                begin
                    if (interval.action == ACT_END)
                    begin
                        entry_next.is_end  = 1'b1;
                        entry_next.level   = 1'b1;
                        entry_next.run_len = RUN_W'(PAD_BITS);
                        entry_next.noise   = (CMP_W'(edge_total_reg) + CMP_W'(1))
                                             < CMP_W'(min_edges);
                        edge_total_next    = '0;
                        state_next         = F_PUSH;
                    end
                    else if (edge_total_reg < EDGE_W'(EDGE_LIMIT - 1))
                    begin
                        edge_total_next  = edge_total_reg + EDGE_W'(1);
                        entry_next.is_end = 1'b0;
                        entry_next.noise  = 1'b0;
                        entry_next.level  = interval.level;
                        if (bit_period_us == '0)
                        begin
                            entry_next.run_len = RUN_W'(RUN_MAX);
                            state_next         = F_PUSH;
                        end
                        else
                        begin
                            rem_next   = {1'b0, interval.duration_us}
                                         + REM_W'(bit_period_us >> 1);
                            quot_next  = '0;
                            step_next  = STEP_W'(DIV_STEPS);
                            state_next = F_DIV;
                        end
                    end
                end
            end
            F_DIV:
            begin
                if (step_reg == STEP_W'(DIV_STEPS))
                begin
                    if (div_ge)
                    begin
                        entry_next.run_len = RUN_W'(RUN_MAX);
                        state_next         = F_PUSH;
                    end
                    else
                    begin
                        step_next = step_reg - STEP_W'(1);
                    end
                end
                else
                begin
                    if (div_ge)
                    begin
                        rem_next = rem_reg - divisor[REM_W-1:0];
                        quot_tmp = quot_reg | (DIV_STEPS'(1) << step_reg);
                    end
                    quot_next = quot_tmp;
                    if (step_reg == '0)
                    begin
                        entry_next.run_len = (quot_tmp == '0) ? RUN_W'(1) : RUN_W'(quot_tmp);
                        state_next         = F_PUSH;
                    end
                    else
                    begin
                        step_next = step_reg - STEP_W'(1);
                    end
                end
            end
            F_PUSH:
            begin
                if (q_ready)
                begin
                    state_next = F_IDLE;
                end
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= F_IDLE;
            edge_total_reg <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            edge_total_reg <= edge_total_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg   <= rem_next;
        quot_reg  <= quot_next;
        step_reg  <= step_next;
        entry_reg <= entry_next;
    end

endmodule

// ===== rtl/core/irpd_queue.sv =====
// Short queue of classified items between the front and back ends.
// Depends on irpd_pkg for the entry type and depth.
module irpd_queue import irpd_pkg::*; (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push_valid,
    output logic     push_ready,
    input  q_entry_t push_data,
    output logic     pop_valid,
    input  logic     pop_ready,
    output q_entry_t pop_data
);

    q_entry_t          slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              do_push;
    logic              do_pop;

    assign push_ready = count_reg < QCNT_W'(QUEUE_DEPTH);
    assign pop_valid  = count_reg != '0;
    assign pop_data   = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                          : wr_ptr_reg + QPTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                          : rd_ptr_reg + QPTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + QCNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== rtl/core/irpd_back.sv =====
// Back end: expands runs into bits one per cycle, deframes UART bytes and
// forms the packet verdict in an output register. Depends on irpd_pkg, irpd_if.
module irpd_back import irpd_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       q_valid,
    output logic       q_ready,
    input  q_entry_t   q_data,
    irpd_out_if.source verdict
);

    typedef enum logic [3:0] {
        B_IDLE = 4'b0001,
        B_RUN  = 4'b0010,
        B_PAD  = 4'b0100,
        B_OUT  = 4'b1000
    } back_state_t;

    back_state_t       state_reg, state_next;
    logic [BIT_W-1:0]  bit_total_reg, bit_total_next;
    logic              phase_reg, phase_next;
    logic [2:0]        dbi_reg, dbi_next;
    logic [7:0]        shift_reg, shift_next;
    logic [BYTE_W-1:0] byte_idx_reg, byte_idx_next;
    logic              match_reg, match_next;
    logic [7:0]        xor_reg, xor_next;
    logic [7:0]        pay_reg [PAY_LEN];
    logic [7:0]        pay_next [PAY_LEN];
    logic [RUN_W-1:0]  cnt_reg, cnt_next;
    logic              level_reg, level_next;
    logic              noise_reg, noise_next;
    logic              out_valid_reg, out_valid_next;
    result_t           res_reg, res_next;

    logic              do_bit;
    logic              bit_val;
    logic              clear;
    logic [7:0]        byte_val;
    logic [SAT_W-1:0]  total_wide;

    assign q_ready = (state_reg == B_IDLE);

    assign verdict.valid         = out_valid_reg;
    assign verdict.status        = res_reg.status;
    assign verdict.preamble_ok   = res_reg.preamble_ok;
    assign verdict.byte_total    = res_reg.byte_total;
    assign verdict.command_flags = res_reg.command_flags;
    assign verdict.fan_speed     = res_reg.fan_speed;
    assign verdict.setpoint_f    = res_reg.setpoint_f;
    assign verdict.extra_a       = res_reg.extra_a;
    assign verdict.extra_b       = res_reg.extra_b;
    assign verdict.checksum_got  = res_reg.checksum_got;
    assign verdict.checksum_calc = res_reg.checksum_calc;

    assign total_wide = SAT_W'(byte_idx_reg);

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        level_next     = level_reg;
        noise_next     = noise_reg;
        out_valid_next = out_valid_reg && !verdict.ready;
        res_next       = res_reg;
        do_bit         = 1'b0;
        bit_val        = level_reg;
        clear          = 1'b0;
        case (state_reg)
            B_IDLE:
            begin
                if (q_valid)
                begin
                    level_next = q_data.level;
                    cnt_next   = q_data.run_len;
                    noise_next = q_data.noise;
                    if (q_data.is_end)
                    begin
                        state_next = q_data.noise ? B_OUT : B_PAD;
                    end
                    else if (bit_total_reg < BIT_W'(BIT_LIMIT - PAD_BITS))
                    begin
                        state_next = B_RUN;
                    end
                end
            end
            B_RUN, B_PAD:
            begin
                if (bit_total_reg < BIT_W'(BIT_LIMIT))
                begin
                    do_bit   = 1'b1;
                    cnt_next = cnt_reg - RUN_W'(1);
                end
                if (bit_total_reg >= BIT_W'(BIT_LIMIT) || cnt_reg == RUN_W'(1))
                begin
                    state_next = (state_reg == B_PAD) ? B_OUT : B_IDLE;
                end
            end
            B_OUT:
            begin
                if (!out_valid_reg || verdict.ready)
                begin
                    out_valid_next = 1'b1;
                    clear          = 1'b1;
                    state_next     = B_IDLE;
                    res_next       = '0;
                    if (noise_reg)
                    begin
                        res_next.status = STATUS_NOISE;
                    end
                    else
                    begin
                        if (byte_idx_reg < BYTE_W'(PACKET_MIN))
                        begin
                            res_next.status = STATUS_SHORT;
                        end
                        else if (xor_reg != pay_reg[PAY_LEN-1])
                        begin
                            res_next.status = STATUS_BAD_SUM;
                        end
                        else
                        begin
                            res_next.status = STATUS_OK;
                        end
                        res_next.preamble_ok = match_reg
                                               && (byte_idx_reg >= BYTE_W'(LEAD_LEN));
                        res_next.byte_total = (total_wide > SAT_W'(TOTAL_MAX))
                                              ? TOTAL_W'(TOTAL_MAX) : TOTAL_W'(total_wide);
                        res_next.command_flags = pay_reg[0];
                        res_next.fan_speed     = pay_reg[1];
                        res_next.setpoint_f    = pay_reg[2];
                        res_next.extra_a       = pay_reg[3];
                        res_next.extra_b       = pay_reg[4];
                        res_next.checksum_got  = pay_reg[5];
                        res_next.checksum_calc = xor_reg;
                    end
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_comb
    begin
        bit_total_next = bit_total_reg;
        phase_next     = phase_reg;
        dbi_next       = dbi_reg;
        shift_next     = shift_reg;
        byte_idx_next  = byte_idx_reg;
        match_next     = match_reg;
        xor_next       = xor_reg;
        byte_val       = shift_reg | (8'(bit_val) << dbi_reg);
        for (int i = 0; i < PAY_LEN; i++)
        begin
            pay_next[i] = pay_reg[i];
        end
        if (clear)
        begin
            bit_total_next = '0;
            phase_next     = 1'b0;
            dbi_next       = '0;
            shift_next     = '0;
            byte_idx_next  = '0;
            match_next     = 1'b1;
            xor_next       = '0;
            for (int i = 0; i < PAY_LEN; i++)
            begin
                pay_next[i] = '0;
            end
        end
        else if (do_bit)
        begin
            bit_total_next = bit_total_reg + BIT_W'(1);
            if (byte_idx_reg < BYTE_W'(BYTE_LIMIT))
            begin
                if (!phase_reg)
                begin
                    if (!bit_val)
                    begin
                        phase_next = 1'b1;
                        dbi_next   = '0;
                        shift_next = '0;
                    end
                end
                else if (dbi_reg == 3'd7)
                begin
                    if (byte_idx_reg < BYTE_W'(LEAD_LEN)
                        && byte_val != LEAD_PATTERN[byte_idx_reg[LEAD_IDX_W-1:0]])
                    begin
                        match_next = 1'b0;
                    end
                    for (int i = 0; i < PAY_LEN; i++)
                    begin
                        if (byte_idx_reg == BYTE_W'(LEAD_LEN + i))
                        begin
                            pay_next[i] = byte_val;
                        end
                    end
                    if (byte_idx_reg >= BYTE_W'(LEAD_LEN)
                        && byte_idx_reg < BYTE_W'(LEAD_LEN + PAY_LEN - 1))
                    begin
                        xor_next = xor_reg ^ byte_val;
                    end
                    byte_idx_next = byte_idx_reg + BYTE_W'(1);
                    phase_next    = 1'b0;
                    dbi_next      = '0;
                    shift_next    = '0;
                end
                else
                begin
                    shift_next = byte_val;
                    dbi_next   = dbi_reg + 3'd1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            bit_total_reg <= '0;
            phase_reg     <= 1'b0;
            dbi_reg       <= '0;
            shift_reg     <= '0;
            byte_idx_reg  <= '0;
            match_reg     <= 1'b1;
            xor_reg       <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < PAY_LEN; i++)
            begin
                pay_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            bit_total_reg <= bit_total_next;
            phase_reg     <= phase_next;
            dbi_reg       <= dbi_next;
            shift_reg     <= shift_next;
            byte_idx_reg  <= byte_idx_next;
            match_reg     <= match_next;
            xor_reg       <= xor_next;
            out_valid_reg <= out_valid_next;
            for (int i = 0; i < PAY_LEN; i++)
            begin
                pay_reg[i] <= pay_next[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg   <= cnt_next;
        level_reg <= level_next;
        noise_reg <= noise_next;
        res_reg   <= res_next;
    end

endmodule

// ===== rtl/core/ir_uart_packet_decoder.sv =====
// IR UART packet decoder, top level with the configuration registers.
// Depends on irpd_pkg, irpd_if, irpd_front, irpd_queue and irpd_back.
//
// The interval channel takes (action, level, duration_us) items. An edge
// interval is rounded to a run of 1 to 16 bit periods; an end-of-burst item
// yields exactly one verdict item on the verdict channel, intervals none.
// The front end accepts an interval, rounds it in a five-step restoring
// divider (skipped when bit_period_us is zero) and pushes it into a
// four-entry queue. The back end pops an entry when idle and shifts one bit
// a cycle into the deframer until the run is spent. An end-of-burst item
// shifts 8 padding bits before the verdict register is loaded; a noise
// burst skips the padding. The bit shifter sets the sustained rate.
// Reset loads bit_period_us = 800 and min_edges = 30 and clears all burst
// state at once. A stalled verdict holds in its output register; the back
// end then waits with the next verdict, the queue fills and interval.ready
// falls. Configuration is written through cfg_we, cfg_index and cfg_wdata.
module ir_uart_packet_decoder import irpd_pkg::*; (
    input  logic                 clk,
    input  logic                 rst_n,
    irpd_in_if.sink              interval,
    irpd_out_if.source           verdict,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_wdata
);

    logic [BP_W-1:0]        bit_period_reg, bit_period_next;
    logic [MIN_EDGES_W-1:0] min_edges_reg, min_edges_next;

    logic     fq_valid;
    logic     fq_ready;
    q_entry_t fq_data;
    logic     qb_valid;
    logic     qb_ready;
    q_entry_t qb_data;

    always_comb
    begin
        bit_period_next = bit_period_reg;
        min_edges_next  = min_edges_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                REG_BIT_PERIOD: bit_period_next = cfg_wdata[BP_W-1:0];
                REG_MIN_EDGES:  min_edges_next  = cfg_wdata[MIN_EDGES_W-1:0];
                default:        bit_period_next = bit_period_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bit_period_reg <= BIT_PERIOD_RESET;
            min_edges_reg  <= MIN_EDGES_RESET;
        end
        else
        begin
            bit_period_reg <= bit_period_next;
            min_edges_reg  <= min_edges_next;
        end
    end

    irpd_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .interval      (interval),
        .bit_period_us (bit_period_reg),
        .min_edges     (min_edges_reg),
        .q_valid       (fq_valid),
        .q_ready       (fq_ready),
        .q_data        (fq_data)
    );

    irpd_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (fq_valid),
        .push_ready (fq_ready),
        .push_data  (fq_data),
        .pop_valid  (qb_valid),
        .pop_ready  (qb_ready),
        .pop_data   (qb_data)
    );

    irpd_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (qb_valid),
        .q_ready (qb_ready),
        .q_data  (qb_data),
        .verdict (verdict)
    );

`ifndef SYNTHESIS
    a_run_len_range: assert property (@(posedge clk) disable iff (!rst_n)
        (qb_valid && !qb_data.is_end) |->
        (qb_data.run_len >= RUN_W'(1) && qb_data.run_len <= RUN_W'(RUN_MAX)))
        else $error("run length out of range in queue");

    a_noise_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (verdict.valid && verdict.status == STATUS_NOISE) |->
        (verdict.byte_total == '0 && !verdict.preamble_ok && verdict.checksum_calc == '0))
        else $error("noise verdict carries packet fields");

    a_preamble_needs_bytes: assert property (@(posedge clk) disable iff (!rst_n)
        (verdict.valid && verdict.preamble_ok) |->
        (verdict.byte_total >= TOTAL_W'(LEAD_LEN)))
        else $error("preamble reported with too few bytes");

    a_byte_total_limit: assert property (@(posedge clk) disable iff (!rst_n)
        verdict.valid |-> (verdict.byte_total <= TOTAL_W'(BYTE_LIMIT)))
        else $error("byte total beyond byte limit");

    a_short_status: assert property (@(posedge clk) disable iff (!rst_n)
        (verdict.valid && verdict.status != STATUS_NOISE
         && verdict.byte_total < TOTAL_W'(PACKET_MIN)) |->
        (verdict.status == STATUS_SHORT))
        else $error("short packet not flagged");
`endif

endmodule

// ===== test/tb_top.sv =====
// Self-checking testbench for ir_uart_packet_decoder.
// Predicts the verdict of each burst from the interval items it accepts and
// checks every verdict item field by field. Depends on irpd_pkg and irpd_if.
module tb_top import irpd_pkg::*; ();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DRAIN_CYCLES = 120;
    localparam int PHASE_ITEMS  = 60;
    localparam int PHASE_ENDS   = 1;
    localparam int SHOWN_ERRORS = 40;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_wdata;

    irpd_in_if  in_if ();
    irpd_out_if out_if ();

    ir_uart_packet_decoder u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .interval  (in_if),
        .verdict   (out_if),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    int error_count  = 0;
    int items_sent   = 0;
    int ends_sent    = 0;
    int src_idle_pct = 0;
    int sink_stall_pct = 0;
    int sink_hold    = 0;

    logic [BP_W-1:0]        cur_bit_period;
    logic [MIN_EDGES_W-1:0] cur_min_edges;

    int         burst_edges;
    int         burst_bits;
    int         burst_bytes;
    bit         in_frame;
    int         frame_bit;
    bit [7:0]   frame_shift;
    bit         lead_match;
    bit [7:0]   sum_acc;
    bit [7:0]   pay_bytes [PAY_LEN];

    result_t verdict_q [$];

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("ir_uart_packet_decoder test failed");
        $finish;
    end

    task automatic report_error(string msg);
        error_count++;
        if (error_count <= SHOWN_ERRORS)
            $display("ERROR at %0t: %s", $realtime, msg);
    endtask

    function automatic void clear_burst_state();
        burst_edges = 0;
        burst_bits  = 0;
        burst_bytes = 0;
        in_frame    = 1'b0;
        frame_bit   = 0;
        frame_shift = '0;
        lead_match  = 1'b1;
        sum_acc     = '0;
        foreach (pay_bytes[k])
            pay_bytes[k] = '0;
    endfunction

    function automatic void shift_in_bit(bit b);
        burst_bits++;
        if (burst_bytes >= BYTE_LIMIT)
            return;
        if (!in_frame)
        begin
            if (b == 1'b0)
            begin
                in_frame    = 1'b1;
                frame_bit   = 0;
                frame_shift = '0;
            end
            return;
        end
        frame_shift[frame_bit] = b;
        frame_bit++;
        if (frame_bit == 8)
        begin
            if (burst_bytes < LEAD_LEN && frame_shift != LEAD_PATTERN[burst_bytes])
                lead_match = 1'b0;
            if (burst_bytes >= LEAD_LEN && burst_bytes < LEAD_LEN + PAY_LEN)
                pay_bytes[burst_bytes - LEAD_LEN] = frame_shift;
            if (burst_bytes >= LEAD_LEN && burst_bytes < LEAD_LEN + PAY_LEN - 1)
                sum_acc ^= frame_shift;
            burst_bytes++;
            in_frame    = 1'b0;
            frame_bit   = 0;
            frame_shift = '0;
        end
    endfunction

    function automatic void decode_item(logic act, logic lvl, logic [DUR_W-1:0] dur);
        result_t v;
        int      run;
        int      bp;
        v  = '0;
        bp = int'(cur_bit_period);
        if (act == ACT_INTERVAL)
        begin
            if (burst_edges >= EDGE_LIMIT - 1)
                return;
            burst_edges++;
            if (burst_bits >= BIT_LIMIT - PAD_BITS)
                return;
            run = (bp == 0) ? RUN_MAX : (int'(dur) + bp / 2) / bp;
            if (run < 1)
                run = 1;
            if (run > RUN_MAX)
                run = RUN_MAX;
            for (int j = 0; j < run && burst_bits < BIT_LIMIT; j++)
                shift_in_bit(lvl);
            return;
        end
        if (burst_edges + 1 < int'(cur_min_edges))
        begin
            v.status = STATUS_NOISE;
        end
        else
        begin
            for (int j = 0; j < PAD_BITS && burst_bits < BIT_LIMIT; j++)
                shift_in_bit(1'b1);
            if (burst_bytes < PACKET_MIN)
                v.status = STATUS_SHORT;
            else if (sum_acc != pay_bytes[PAY_LEN - 1])
                v.status = STATUS_BAD_SUM;
            else
                v.status = STATUS_OK;
            v.preamble_ok   = lead_match && burst_bytes >= LEAD_LEN;
            v.byte_total    = TOTAL_W'(burst_bytes > TOTAL_MAX ? TOTAL_MAX : burst_bytes);
            v.command_flags = pay_bytes[0];
            v.fan_speed     = pay_bytes[1];
            v.setpoint_f    = pay_bytes[2];
            v.extra_a       = pay_bytes[3];
            v.extra_b       = pay_bytes[4];
            v.checksum_got  = pay_bytes[5];
            v.checksum_calc = sum_acc;
        end
        verdict_q.push_back(v);
        clear_burst_state();
    endfunction

    task automatic check_field(string name, logic [7:0] got, logic [7:0] want);
        if (got !== want)
            report_error($sformatf("%s got 0x%0h expected 0x%0h", name, got, want));
    endtask

    always @(posedge clk)
    begin
        result_t want;
        if (rst_n === 1'b1 && out_if.valid === 1'b1 && out_if.ready === 1'b1)
        begin
            if (verdict_q.size() == 0)
            begin
                report_error("verdict item with no burst end pending");
            end
            else
            begin
                want = verdict_q.pop_front();
                check_field("status", 8'(out_if.status), 8'(want.status));
                check_field("preamble_ok", 8'(out_if.preamble_ok), 8'(want.preamble_ok));
                check_field("byte_total", 8'(out_if.byte_total), 8'(want.byte_total));
                check_field("command_flags", out_if.command_flags, want.command_flags);
                check_field("fan_speed", out_if.fan_speed, want.fan_speed);
                check_field("setpoint_f", out_if.setpoint_f, want.setpoint_f);
                check_field("extra_a", out_if.extra_a, want.extra_a);
                check_field("extra_b", out_if.extra_b, want.extra_b);
                check_field("checksum_got", out_if.checksum_got, want.checksum_got);
                check_field("checksum_calc", out_if.checksum_calc, want.checksum_calc);
            end
        end
    end

    initial
    begin
        out_if.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (sink_hold > 0)
            begin
                out_if.ready <= 1'b0;
                sink_hold--;
            end
            else
            begin
                out_if.ready <= ($urandom_range(99) >= sink_stall_pct);
            end
        end
    end

    task automatic set_idle_mode(int mode);
        case (mode)
            0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
            1: begin src_idle_pct = 48; sink_stall_pct = 0;  end
            2: begin src_idle_pct = 0;  sink_stall_pct = 48; end
            default: begin src_idle_pct = 36; sink_stall_pct = 36; end
        endcase
    endtask

    task automatic send_item(logic act, logic lvl, logic [DUR_W-1:0] dur);
        while ($urandom_range(99) < src_idle_pct)
        begin
            in_if.valid <= 1'b0;
            @(posedge clk);
        end
        in_if.valid       <= 1'b1;
        in_if.action      <= act;
        in_if.level       <= lvl;
        in_if.duration_us <= dur;
        do
            @(posedge clk);
        while (in_if.ready !== 1'b1);
        decode_item(act, lvl, dur);
        items_sent++;
        if (act == ACT_END)
            ends_sent++;
    endtask

    task automatic send_end();
        send_item(ACT_END, 1'($urandom_range(1)), DUR_W'($urandom));
    endtask

    task automatic send_run(bit lvl, int len);
        int bp;
        int dur;
        bp = int'(cur_bit_period);
        if (bp == 0)
            dur = int'($urandom_range(65535));
        else
            dur = len * bp + int'($urandom_range(bp - 1)) - bp / 2;
        if (dur < 0)
            dur = 0;
        if (dur > 65535)
            dur = 65535;
        send_item(ACT_INTERVAL, lvl, DUR_W'(dur));
    endtask

    task automatic wait_drain();
        in_if.valid <= 1'b0;
        while (verdict_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        if (idx == REG_BIT_PERIOD)
            cur_bit_period = data[BP_W-1:0];
        else
            cur_min_edges = data[MIN_EDGES_W-1:0];
    endtask

    task automatic set_config(int bp, int min_edges);
        logic [CFG_W-1:0] me_word;
        wait_drain();
        me_word = CFG_W'($urandom);
        me_word[MIN_EDGES_W-1:0] = MIN_EDGES_W'(min_edges);
        write_reg(REG_BIT_PERIOD, CFG_W'(bp));
        write_reg(REG_MIN_EDGES, me_word);
    endtask

    task automatic send_packet(int nbytes, bit lead_good, bit sum_good, bit corrupt);
        bit [7:0] pkt [$];
        bit       stream [$];
        bit [7:0] b;
        bit [7:0] sum;
        int       bad_k;
        int       k;
        int       run;
        bad_k = lead_good ? -1 : int'($urandom_range(LEAD_LEN - 1));
        for (int i = 0; i < nbytes; i++)
        begin
            if (i < LEAD_LEN && i != bad_k)
                b = LEAD_PATTERN[i];
            else
                b = 8'($urandom);
            pkt.push_back(b);
        end
        if (nbytes >= PACKET_MIN)
        begin
            sum = '0;
            for (int i = LEAD_LEN; i < LEAD_LEN + PAY_LEN - 1; i++)
                sum ^= pkt[i];
            pkt[LEAD_LEN + PAY_LEN - 1] = sum_good ? sum : sum ^ 8'($urandom_range(1, 255));
        end
        foreach (pkt[i])
        begin
            stream.push_back(1'b0);
            for (int j = 0; j < 8; j++)
                stream.push_back(pkt[i][j]);
            repeat ($urandom_range(9) == 0 ? 3 : $urandom_range(1, 2))
                stream.push_back(1'b1);
        end
        if (corrupt && stream.size() > 0)
        begin
            k = int'($urandom_range(stream.size() - 1));
            stream[k] = ~stream[k];
        end
        while (stream.size() > 0 && stream[$] == 1'b1)
            void'(stream.pop_back());
        k = 0;
        while (k < stream.size())
        begin
            run = 1;
            while (k + run < stream.size() && stream[k + run] == stream[k])
                run++;
            send_run(stream[k], run);
            k += run;
        end
        send_end();
    endtask

    task automatic send_noise_burst();
        repeat ($urandom_range(40))
            send_item(ACT_INTERVAL, 1'($urandom_range(1)), DUR_W'($urandom));
        send_end();
    endtask

    task automatic test_directed_cases();
        set_idle_mode(0);
        send_end();
        set_config(800, 0);
        send_item(ACT_INTERVAL, 1'b0, 16'd0);
        send_item(ACT_INTERVAL, 1'b1, 16'hFFFF);
        send_item(ACT_INTERVAL, 1'b0, 16'd399);
        send_item(ACT_INTERVAL, 1'b1, 16'd400);
        send_item(ACT_INTERVAL, 1'b0, 16'd1199);
        send_item(ACT_INTERVAL, 1'b1, 16'd1200);
        send_end();
        set_config(0, 1023);
        send_item(ACT_INTERVAL, 1'b0, 16'd5);
        send_item(ACT_INTERVAL, 1'b1, 16'hAAAA);
        send_item(ACT_INTERVAL, 1'b0, 16'h5555);
        send_end();
        set_config(0, 2);
        send_item(ACT_INTERVAL, 1'b0, 16'd12345);
        send_item(ACT_INTERVAL, 1'b1, 16'd0);
        send_end();
        set_config(16383, 1);
        send_item(ACT_INTERVAL, 1'b0, 16'hFFFF);
        send_item(ACT_INTERVAL, 1'b1, 16'd8191);
        send_item(ACT_INTERVAL, 1'b0, 16'd8192);
        send_end();
    endtask

    task automatic test_random_traffic();
        int bp_list [4] = '{800, 100, 10000, -1};
        int me_list [4] = '{30, 2, 20, -1};
        int start_items;
        int start_ends;
        int pick;
        int bp;
        int me;
        for (int p = 0; p < 4; p++)
        begin
            bp = bp_list[p] < 0 ? int'($urandom_range(100, 10000)) : bp_list[p];
            me = me_list[p] < 0 ? int'($urandom_range(2, 64)) : me_list[p];
            set_config(bp, me);
            set_idle_mode(p % 4);
            start_items = items_sent;
            start_ends  = ends_sent;
            while (items_sent - start_items < PHASE_ITEMS || ends_sent - start_ends < PHASE_ENDS)
            begin
                pick = int'($urandom_range(99));
                if (pick < 60)
                    send_packet(PACKET_MIN, $urandom_range(99) < 85, $urandom_range(99) < 70, 0);
                else if (pick < 70)
                    send_packet(int'($urandom_range(1, PACKET_MIN - 1)),
                                1'($urandom_range(1)), 1, 0);
                else if (pick < 78)
                    send_packet(int'($urandom_range(PACKET_MIN + 1, 40)),
                                1'($urandom_range(1)), 1, 0);
                else if (pick < 88)
                    send_packet(PACKET_MIN, 1, 1, 1);
                else
                    send_noise_burst();
            end
        end
    endtask

    task automatic test_edge_overflow();
        set_config(100, 512);
        set_idle_mode(0);
        for (int i = 0; i < EDGE_LIMIT + 6; i++)
            send_run(i[0], 1);
        send_end();
        set_config(100, 20);
        set_idle_mode(3);
        for (int i = 0; i < 18; i++)
            send_run(i[0], 1);
        send_end();
        for (int i = 0; i < 19; i++)
            send_run(i[0], 1);
        send_end();
    endtask

    task automatic test_bit_overflow();
        set_config(100, 2);
        set_idle_mode(1);
        send_item(ACT_INTERVAL, 1'b0, 16'd700);
        for (int i = 0; i < 130; i++)
            send_item(ACT_INTERVAL, i[0], 16'd1600);
        send_end();
    endtask

    task automatic test_output_backpressure();
        set_config(800, 1023);
        set_idle_mode(0);
        sink_hold = 400;
        repeat (16)
        begin
            send_item(ACT_INTERVAL, 1'($urandom_range(1)), DUR_W'($urandom));
            send_end();
        end
        set_config(800, 2);
        sink_hold = 300;
        repeat (6)
            send_packet(int'($urandom_range(1, 3)), 1, 1, 0);
        wait_drain();
    endtask

    initial
    begin
        rst_n             <= 1'b0;
        cfg_we            <= 1'b0;
        cfg_index         <= REG_BIT_PERIOD;
        cfg_wdata         <= '0;
        in_if.valid       <= 1'b0;
        in_if.action      <= ACT_INTERVAL;
        in_if.level       <= 1'b0;
        in_if.duration_us <= '0;
        cur_bit_period = BIT_PERIOD_RESET;
        cur_min_edges  = MIN_EDGES_RESET;
        clear_burst_state();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_cases();
        test_random_traffic();
        test_edge_overflow();
        test_bit_overflow();
        test_output_backpressure();

        wait_drain();
        if (error_count == 0)
            $display("ir_uart_packet_decoder test passed");
        else
            $display("ir_uart_packet_decoder test failed");
        $finish;
    end

endmodule
